// File: rtl/core/sltr_pkg.sv
// Package: shared types, bus addresses and request kind codes for the scanline IRQ tracker.
package sltr_pkg;

  localparam int unsigned VisibleLines = 240;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_HSYNC = 2'd2;

  localparam logic [15:0] ADDR_SPLIT_SCROLL = 16'h5201;
  localparam logic [15:0] ADDR_IRQ_COMPARE  = 16'h5203;
  localparam logic [15:0] ADDR_IRQ_STATUS   = 16'h5204;
  localparam logic [15:0] ADDR_MUL_LO       = 16'h5205;
  localparam logic [15:0] ADDR_MUL_HI       = 16'h5206;

  localparam logic [9:0] ROW_MASK       = 10'h3E0;
  localparam logic [9:0] ROW_LAST_30    = 10'h3A0;
  localparam logic [9:0] ROW_LAST_32    = 10'h3E0;
  localparam logic [9:0] ROW_STEP       = 10'h020;
  localparam logic [7:0] IDLE_LIMIT     = 8'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
    logic        display_on;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic [9:0] split_row_addr;
    logic [2:0] split_fine_y;
  } result_t;

endpackage

// File: rtl/core/sltr_in_reg.sv
// Input register: holds one accepted request until the engine consumes it.
module sltr_in_reg
  import sltr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  consume_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // Take a new request when empty or when the held one leaves this cycle.
  assign in_ready_o = !valid_q || consume_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/core/sltr_engine.sv
// Engine: IRQ, multiplier and split-row state with the per-request update logic.
module sltr_engine
  import sltr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_data_i,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam logic [8:0] VIS_LINES = 9'(VisibleLines);

  logic       alt_q;
  logic       match_q, match_d;
  logic       in_frame_q, in_frame_d;
  logic       irq_en_q, irq_en_d;
  logic [7:0] cmp_q, cmp_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] idle_q, idle_d;
  logic [7:0] fa_q, fa_d;
  logic [7:0] fb_q, fb_d;
  logic [7:0] scroll_q, scroll_d;
  logic [9:0] row_q, row_d;
  logic [2:0] fine_q, fine_d;
  logic       irq_q, irq_d;
  logic [7:0] rd;
  logic [15:0] prod;
  logic       visible;
  logic [9:0] row_hi;

  assign prod    = fa_q * fb_q;
  assign visible = item_i.display_on && (item_i.scanline < VIS_LINES);
  assign row_hi  = row_q & ROW_MASK;

  always_comb begin
    match_d    = match_q;
    in_frame_d = in_frame_q;
    irq_en_d   = irq_en_q;
    cmp_d      = cmp_q;
    cnt_d      = cnt_q;
    idle_d     = idle_q;
    fa_d       = fa_q;
    fb_d       = fb_q;
    scroll_d   = scroll_q;
    row_d      = row_q;
    fine_d     = fine_q;
    irq_d      = irq_q;
    rd         = 8'd0;
    case (item_i.kind)
      KIND_READ: begin
        case (item_i.address)
          ADDR_IRQ_STATUS: begin
            rd      = {match_q, in_frame_q, 6'd0};
            match_d = 1'b0;
            irq_d   = 1'b0;
          end
          ADDR_MUL_LO: rd = prod[7:0];
          ADDR_MUL_HI: rd = prod[15:8];
          default:     rd = item_i.address[15:8];
        endcase
      end
      KIND_WRITE: begin
        case (item_i.address)
          ADDR_SPLIT_SCROLL: scroll_d = item_i.write_data;
          ADDR_IRQ_COMPARE: begin
            cmp_d = item_i.write_data;
            irq_d = 1'b0;
          end
          ADDR_IRQ_STATUS: begin
            irq_en_d = item_i.write_data[7];
            irq_d    = 1'b0;
          end
          ADDR_MUL_LO: fa_d = item_i.write_data;
          ADDR_MUL_HI: fb_d = item_i.write_data;
          default: ;
        endcase
      end
      KIND_HSYNC: begin
        // Alternate timing compares before the count moves.
        if (alt_q && (cnt_q == cmp_q)) begin
          match_d = 1'b1;
        end
        if (visible) begin
          cnt_d      = cnt_q + 8'd1;
          in_frame_d = 1'b1;
          idle_d     = 8'd0;
        end else if (alt_q) begin
          cnt_d      = 8'd0;
          match_d    = 1'b0;
          in_frame_d = 1'b0;
        end
        if (!alt_q) begin
          if (cnt_d == cmp_q) begin
            match_d = 1'b1;
          end
          idle_d = idle_d + 8'd1;
          // Out of frame too long: drop the counter, status and IRQ.
          if (idle_d > IDLE_LIMIT) begin
            cnt_d      = 8'd0;
            match_d    = 1'b0;
            in_frame_d = 1'b0;
            irq_d      = 1'b0;
          end
        end
        if (irq_en_q && match_d && in_frame_d) begin
          irq_d = 1'b1;
        end
        if (item_i.scanline == 9'd0) begin
          fine_d = scroll_q[2:0];
          row_d  = {scroll_q[7:3], 5'd0};
        end else if (item_i.display_on) begin
          if (fine_q == 3'd7) begin
            fine_d = 3'd0;
            if ((row_hi == ROW_LAST_30) || (row_hi == ROW_LAST_32)) begin
              row_d = {5'd0, row_q[4:0]};
            end else begin
              row_d = row_q + ROW_STEP;
            end
          end else begin
            fine_d = fine_q + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_q      <= 1'b0;
      match_q    <= 1'b0;
      in_frame_q <= 1'b0;
      irq_en_q   <= 1'b0;
      cmp_q      <= 8'd0;
      cnt_q      <= 8'd0;
      idle_q     <= 8'd0;
      fa_q       <= 8'd0;
      fb_q       <= 8'd0;
      scroll_q   <= 8'd0;
      row_q      <= 10'd0;
      fine_q     <= 3'd0;
      irq_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        alt_q <= cfg_data_i;
      end
      if (fire_i) begin
        match_q    <= match_d;
        in_frame_q <= in_frame_d;
        irq_en_q   <= irq_en_d;
        cmp_q      <= cmp_d;
        cnt_q      <= cnt_d;
        idle_q     <= idle_d;
        fa_q       <= fa_d;
        fb_q       <= fb_d;
        scroll_q   <= scroll_d;
        row_q      <= row_d;
        fine_q     <= fine_d;
        irq_q      <= irq_d;
      end
    end
  end

  assign result_o.read_data      = rd;
  assign result_o.irq_out        = irq_d;
  assign result_o.split_row_addr = row_d;
  assign result_o.split_fine_y   = fine_d;

endmodule

// File: rtl/core/scanline_irq_and_split_tracker.sv
// Top level: scanline IRQ and split-screen tracker with input and result registers.
//
// Usage:
//   Requests enter on the in channel (in_valid_i / in_ready_o): kind_i selects a
//   bus read, a bus write or an hsync event; the other fields carry its payload.
//   Every request yields exactly one result on the out channel
//   (out_valid_o / out_ready_i): read data, IRQ level and split row / fine Y.
//   The cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the alternate
//   IRQ timing bit; it is always ready and must only be written while idle.
// Timing:
//   A request is registered on acceptance and processed once the result slot is
//   free or drains; its result is then loaded into the result register and
//   is valid on the out channel. One request per cycle is sustained while
//   out_ready_i is high; the only loop is the state update in the engine.
// Reset and stalls:
//   Reset (rst_ni low, asynchronous) clears all state and both pipeline stages.
//   When out_ready_i is low the result register holds, one more request may
//   wait in the input register, and in_ready_o then drops until the result
//   is taken.
module scanline_irq_and_split_tracker
  import sltr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [8:0]  scanline_i,
  input  logic        display_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        irq_out_o,
  output logic [9:0]  split_row_addr_o,
  output logic [2:0]  split_fine_y_o
);

  item_t   item_in;
  item_t   item_q;
  logic    in_valid_q;
  logic    fire;
  result_t result_d;
  result_t result_q;
  logic    out_valid_q, out_valid_d;

  assign item_in.kind       = kind_i;
  assign item_in.address    = address_i;
  assign item_in.write_data = write_data_i;
  assign item_in.scanline   = scanline_i;
  assign item_in.display_on = display_on_i;

  assign cfg_ready_o = 1'b1;

  // Process the held request whenever the result slot is free or drains now.
  assign fire = in_valid_q && (!out_valid_q || out_ready_i);

  sltr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .item_i    (item_in),
    .consume_i (fire),
    .valid_o   (in_valid_q),
    .item_o    (item_q)
  );

  sltr_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .fire_i    (fire),
    .item_i    (item_q),
    .result_o  (result_d)
  );

  assign out_valid_d = fire ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = result_q.read_data;
  assign irq_out_o        = result_q.irq_out;
  assign split_row_addr_o = result_q.split_row_addr;
  assign split_fine_y_o   = result_q.split_fine_y;

`ifndef NO_ASSERTIONS
  a_stall_only_on_backpressure: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i)
  ) else $error("input stalled without output backpressure");

  a_held_request_moves: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_o) |=> out_valid_o
  ) else $error("held request did not reach the result register");

  a_row_column_bits_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (split_row_addr_o[4:0] == 5'd0)
  ) else $error("split row address has nonzero column bits");
`endif

endmodule
